// ===== sv/pip_pkg.sv =====
// Shared constants, register codes and sequencer states for the point-in-polygon test.
`timescale 1ns / 1ps
`default_nettype none
package pip_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = 6;
	localparam int COORD_W      = 24;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int ADDR_W       = 5;
	localparam int IN_DATA_W    = 80;
	localparam int OUT_DATA_W   = 8;

	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5,
		REG_COUNT = 3'd6,
		REG_NONE  = 3'd7
	} reg_idx_t;

	typedef enum logic [0:0] {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BOX,
		ST_PREV,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_EDGE_C,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== sv/point_in_polygon_test.sv =====
// Point-in-polygon test: vertex store, bounding box and crossing-number edge walk.
//
// Input stream (s_axis_*): one item per command. tuser[0] is the command:
// write-vertex stores x and y in the given slot and gives no result; query
// tests a point and gives exactly one result item on m_axis_*.
// Result: tdata[0] inside, tdata[1] in box.
// Box limits and vertex count are set over the APB port, one register per
// word (min x, y, z, max x, y, z, count); write them only while idle.
// A write item leaves the block idle and ready for the next item. A query
// whose point is outside the box, or with the count zero, skips the edge
// walk; else it walks one edge per vertex (at most 32): each edge needs a
// vertex memory read, two passes through the single 25x25 multiplier and a compare.
// One item is worked on at a time; s_axis_tready is low during a query.
// The result sits in an output register, so the next item is taken while it
// waits; a query that finishes while the old result is still stalled holds
// until the receiver takes it.
// Reset clears the box and count registers to zero, returns to idle and drops valid; the vertex memory is
// not cleared and a slot must be written before a query reads it.
`timescale 1ns / 1ps
`default_nettype none
module point_in_polygon_test (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output      logic                            s_axis_tready,
	// vertex_index[4:0], coord_x[28:5], coord_y[52:29], coord_z[76:53], zero pad
	input  wire logic [pip_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// command[0]
	input  wire logic [0:0]                      s_axis_tuser,
	output      logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// inside_res[0], in_box[1], zero pad
	output      logic [pip_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [pip_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [31:0]                     pwdata,
	output      logic [31:0]                     prdata,
	output      logic                            pready
);
	import pip_pkg::*;

	state_t state_q, state_d;

	logic signed [COORD_W-1:0] min_x_q, min_y_q, min_z_q, max_x_q, max_y_q, max_z_q;
	logic [CNT_W-1:0]          count_q;

	logic [2*COORD_W-1:0]      mem [MAX_VERTICES];
	logic [2*COORD_W-1:0]      rd_q;
	logic [VIDX_W-1:0]         rd_addr;

	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
	logic [CNT_W-1:0]          n_q;
	logic [VIDX_W-1:0]         cur_q;
	logic signed [DIFF_W-1:0]  dpx_q, dy_q, dxe_q, dpy_q;
	logic                      straddle_q;
	logic signed [PROD_W-1:0]  lhs_q;
	logic                      parity_q, in_box_q;
	logic                      out_valid_q;
	logic [1:0]                out_data_q;

	logic [VIDX_W-1:0]         in_idx;
	logic signed [COORD_W-1:0] in_x, in_y, in_z;
	logic                      in_accept, out_free;
	logic                      box_ok;
	logic [CNT_W-1:0]          n_eff;
	logic signed [COORD_W-1:0] cur_x, cur_y;
	logic                      last_edge;
	logic signed [DIFF_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic                      left;
	logic                      cfg_wr;
	reg_idx_t                  cfg_idx;

	assign in_idx = s_axis_tdata[VIDX_W-1:0];
	assign in_x   = s_axis_tdata[5 +: COORD_W];
	assign in_y   = s_axis_tdata[5 + COORD_W +: COORD_W];
	assign in_z   = s_axis_tdata[5 + 2*COORD_W +: COORD_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_data_q};

	// config port
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0;
			min_y_q <= '0;
			min_z_q <= '0;
			max_x_q <= '0;
			max_y_q <= '0;
			max_z_q <= '0;
			count_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MIN_X: min_x_q <= pwdata[COORD_W-1:0];
				REG_MIN_Y: min_y_q <= pwdata[COORD_W-1:0];
				REG_MIN_Z: min_z_q <= pwdata[COORD_W-1:0];
				REG_MAX_X: max_x_q <= pwdata[COORD_W-1:0];
				REG_MAX_Y: max_y_q <= pwdata[COORD_W-1:0];
				REG_MAX_Z: max_z_q <= pwdata[COORD_W-1:0];
				REG_COUNT: count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_MIN_X: prdata = {{(32-COORD_W){1'b0}}, min_x_q};
			REG_MIN_Y: prdata = {{(32-COORD_W){1'b0}}, min_y_q};
			REG_MIN_Z: prdata = {{(32-COORD_W){1'b0}}, min_z_q};
			REG_MAX_X: prdata = {{(32-COORD_W){1'b0}}, max_x_q};
			REG_MAX_Y: prdata = {{(32-COORD_W){1'b0}}, max_y_q};
			REG_MAX_Z: prdata = {{(32-COORD_W){1'b0}}, max_z_q};
			REG_COUNT: prdata = {{(32-CNT_W){1'b0}}, count_q};
			default:   prdata = '0;
		endcase
	end

	// vertex memory, {y, x} per slot
	always_ff @(posedge clk) begin
		if (in_accept && s_axis_tuser[0] == CMD_WRITE)
			mem[in_idx] <= {in_y, in_x};
		rd_q <= mem[rd_addr];
	end

	assign cur_x = rd_q[COORD_W-1:0];
	assign cur_y = rd_q[2*COORD_W-1:COORD_W];

	assign box_ok = (min_x_q <= px_q) && (px_q <= max_x_q) &&
	                (min_y_q <= py_q) && (py_q <= max_y_q) &&
	                (min_z_q <= pz_q) && (pz_q <= max_z_q);
	assign n_eff  = (count_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_q;
	assign last_edge = (CNT_W'(cur_q) == n_q - CNT_W'(1));

	// shared multiplier: lhs in EDGE_B, rhs in EDGE_C
	always_comb begin
		if (state_q == ST_EDGE_C) begin
			mul_a = dxe_q;
			mul_b = dpy_q;
		end else begin
			mul_a = dpx_q;
			mul_b = dy_q;
		end
	end
	assign prod = mul_a * mul_b;
	assign left = dy_q[DIFF_W-1] ? (lhs_q > prod) : (lhs_q < prod);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_accept && s_axis_tuser[0] == CMD_QUERY) state_d = ST_BOX;
			ST_BOX:    state_d = (box_ok && n_eff != '0) ? ST_PREV : ST_DONE;
			ST_PREV:   state_d = ST_EDGE_A;
			ST_EDGE_A: state_d = ST_EDGE_B;
			ST_EDGE_B: state_d = ST_EDGE_C;
			ST_EDGE_C: state_d = last_edge ? ST_DONE : ST_EDGE_A;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory read address
	always_comb begin
		case (state_q)
			ST_BOX:    rd_addr = VIDX_W'(n_eff - CNT_W'(1));
			ST_PREV:   rd_addr = '0;
			ST_EDGE_B: rd_addr = cur_q + VIDX_W'(1);
			ST_EDGE_C: rd_addr = cur_q + VIDX_W'(1);
			default:   rd_addr = cur_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q <= in_x;
				py_q <= in_y;
				pz_q <= in_z;
			end
			ST_BOX: begin
				in_box_q <= box_ok;
				parity_q <= 1'b0;
				n_q      <= n_eff;
			end
			ST_PREV: begin
				prev_x_q <= cur_x;
				prev_y_q <= cur_y;
				cur_q    <= '0;
			end
			ST_EDGE_A: begin
				dpx_q      <= DIFF_W'(px_q) - DIFF_W'(cur_x);
				dy_q       <= DIFF_W'(prev_y_q) - DIFF_W'(cur_y);
				dxe_q      <= DIFF_W'(prev_x_q) - DIFF_W'(cur_x);
				dpy_q      <= DIFF_W'(py_q) - DIFF_W'(cur_y);
				straddle_q <= ((cur_y <= py_q) && (py_q < prev_y_q)) ||
				              ((prev_y_q <= py_q) && (py_q < cur_y));
				prev_x_q   <= cur_x;
				prev_y_q   <= cur_y;
			end
			ST_EDGE_B: lhs_q <= prod;
			ST_EDGE_C: begin
				if (straddle_q && left)
					parity_q <= !parity_q;
				cur_q <= cur_q + VIDX_W'(1);
			end
			ST_DONE: if (out_free) out_data_q <= {in_box_q, in_box_q && parity_q};
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/pip_checker.sv =====
// Port-level checks for the point-in-polygon test, bound to point_in_polygon_test.
`timescale 1ns / 1ps
`default_nettype none
module pip_assertions (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic [0:0]                      s_axis_tuser,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [pip_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import pip_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item dropped while stalled");

	a_inside_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && !m_axis_tdata[1]))
		else $error("inside reported for a point outside the box");

	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_WRITE |=> s_axis_tready)
		else $error("vertex write held off the next item");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_QUERY |=> !s_axis_tready)
		else $error("ready high straight after a query");

endmodule

bind point_in_polygon_test pip_assertions u_pip_assertions (.*);
`default_nettype wire

// ===== tb/sv/pip_checker.sv =====
// Checker for the point-in-polygon block: mirrors registers and vertices, predicts and compares.
`timescale 1ns / 1ps
module pip_checker
	import pip_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [IN_DATA_W-1:0]   s_tdata,
	input  wire logic [0:0]             s_tuser,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [OUT_DATA_W-1:0]  m_tdata,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic                   pready,
	input  wire logic [ADDR_W-1:0]      paddr,
	input  wire logic [31:0]            pwdata,
	output int                          fail_count,
	output int                          pending
);

	localparam int X_LSB = VIDX_W;
	localparam int Y_LSB = X_LSB + COORD_W;
	localparam int Z_LSB = Y_LSB + COORD_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef struct packed {
		logic in_box;
		logic in_poly;
	} verdict_t;

	coord_t           box_lo [3];
	coord_t           box_hi [3];
	logic [CNT_W-1:0] n_vert;
	coord_t           vert_x [MAX_VERTICES];
	coord_t           vert_y [MAX_VERTICES];
	verdict_t         awaited_verdicts [$];
	int               n_fail;

	// box test, then crossing-number walk over every edge, starting with the last vertex to vertex 0
	function automatic verdict_t classify_point(coord_t px, coord_t py, coord_t pz);
		verdict_t v;
		longint   x0, y0, x1, y1, dy, lhs, rhs;
		int       n, prev;
		logic     odd, left;
		v = '0;
		if (px < box_lo[0] || px > box_hi[0] || py < box_lo[1] || py > box_hi[1] ||
		    pz < box_lo[2] || pz > box_hi[2])
			return v;
		v.in_box = 1'b1;
		n = (n_vert > MAX_VERTICES) ? MAX_VERTICES : int'(n_vert);
		odd = 1'b0;
		prev = n - 1;
		for (int cur = 0; cur < n; cur++) begin
			x0 = vert_x[prev];
			y0 = vert_y[prev];
			x1 = vert_x[cur];
			y1 = vert_y[cur];
			prev = cur;
			if ((y1 <= py && py < y0) || (y0 <= py && py < y1)) begin
				dy = y0 - y1;
				lhs = (px - x1) * dy;
				rhs = (x0 - x1) * (py - y1);
				left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
				if (left)
					odd = ~odd;
			end
		end
		v.in_poly = odd;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t         got, want;
		logic [VIDX_W-1:0] idx;
		coord_t           px, py, pz;
		if (!arst_n) begin
			box_lo = '{default: '0};
			box_hi = '{default: '0};
			n_vert = '0;
			awaited_verdicts.delete();
			n_fail = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_MIN_X: box_lo[0] = pwdata[COORD_W-1:0];
					REG_MIN_Y: box_lo[1] = pwdata[COORD_W-1:0];
					REG_MIN_Z: box_lo[2] = pwdata[COORD_W-1:0];
					REG_MAX_X: box_hi[0] = pwdata[COORD_W-1:0];
					REG_MAX_Y: box_hi[1] = pwdata[COORD_W-1:0];
					REG_MAX_Z: box_hi[2] = pwdata[COORD_W-1:0];
					REG_COUNT: n_vert = pwdata[CNT_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.in_poly = m_tdata[0];
				got.in_box  = m_tdata[1];
				if (awaited_verdicts.size() == 0) begin
					$display("%0t pip_checker: unexpected result inside=%0b in_box=%0b, expected none",
						$time, got.in_poly, got.in_box);
					n_fail++;
				end else begin
					want = awaited_verdicts.pop_front();
					if (got != want) begin
						$display("%0t pip_checker: expected inside=%0b in_box=%0b, got inside=%0b in_box=%0b",
							$time, want.in_poly, want.in_box, got.in_poly, got.in_box);
						n_fail++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				idx = s_tdata[VIDX_W-1:0];
				px = s_tdata[X_LSB +: COORD_W];
				py = s_tdata[Y_LSB +: COORD_W];
				pz = s_tdata[Z_LSB +: COORD_W];
				if (s_tuser[0] == CMD_WRITE) begin
					if (idx < MAX_VERTICES) begin
						vert_x[idx] = px;
						vert_y[idx] = py;
					end
				end else begin
					awaited_verdicts.push_back(classify_point(px, py, pz));
				end
			end
			fail_count <= n_fail;
			pending <= awaited_verdicts.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the point-in-polygon block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import pip_pkg::*;

	localparam int     RESET_CYCLES   = 12;
	localparam int     SETTLE_CYCLES  = 120;
	localparam int     WATCHDOG_LIMIT = 5000;
	localparam int     PHASES         = 16;
	localparam int     PHASE_ITEMS    = 110;
	localparam int     PAD_W          = IN_DATA_W - 3 * COORD_W - VIDX_W;
	localparam longint C_MIN          = -8388608;
	localparam longint C_MAX          = 8388607;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata  = '0;
	logic [0:0]             s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [ADDR_W-1:0]      paddr    = '0;
	logic [31:0]            pwdata   = '0;
	logic [31:0]            prdata;
	logic                   pready;

	int     fail_count;
	int     pending;
	int     src_idle  = 0;
	int     dst_stall = 0;
	int     span      = 32;
	int     n_used    = 0;
	longint ctr       = 0;
	longint vx [MAX_VERTICES];
	longint vy [MAX_VERTICES];
	longint bound_lo [3];
	longint bound_hi [3];

	point_in_polygon_test u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	pip_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) m_tready <= ($urandom_range(99) >= dst_stall);

	function automatic longint clamp24(longint v);
		if (v < C_MIN)
			return C_MIN;
		if (v > C_MAX)
			return C_MAX;
		return v;
	endfunction

	function automatic longint near_ctr();
		return clamp24(ctr + longint'($urandom_range(2 * span)) - span);
	endfunction

	function automatic longint any_coord();
		logic [COORD_W-1:0] r;
		r = COORD_W'($urandom);
		return longint'(signed'(r));
	endfunction

	// bias query coordinates onto box bounds and vertex values to hit the ties
	function automatic longint pick_axis(int a);
		int r;
		r = $urandom_range(9);
		case (r)
			0: return bound_lo[a];
			1: return bound_hi[a];
			2: begin
				if (a < 2 && n_used > 0)
					return (a == 0) ? vx[$urandom_range(n_used - 1)] : vy[$urandom_range(n_used - 1)];
				return near_ctr();
			end
			3: return any_coord();
			default: begin
				if (a < 2)
					return near_ctr();
				if (bound_lo[a] <= bound_hi[a])
					return bound_lo[a] + longint'($urandom_range(int'(bound_hi[a] - bound_lo[a])));
				return any_coord();
			end
		endcase
	endfunction

	task automatic send_item(cmd_t cmd, logic [VIDX_W-1:0] idx, longint x, longint y, longint z);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{PAD_W{1'b0}}, z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0], idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	// upper bits carry junk; the block keeps only the field width
	task automatic set_regs(longint lx, longint ly, longint lz, longint hx, longint hy,
	                        longint hz, int cnt);
		write_reg(REG_MIN_X, {8'($urandom), lx[COORD_W-1:0]});
		write_reg(REG_MIN_Y, {8'($urandom), ly[COORD_W-1:0]});
		write_reg(REG_MIN_Z, {8'($urandom), lz[COORD_W-1:0]});
		write_reg(REG_MAX_X, {8'($urandom), hx[COORD_W-1:0]});
		write_reg(REG_MAX_Y, {8'($urandom), hy[COORD_W-1:0]});
		write_reg(REG_MAX_Z, {8'($urandom), hz[COORD_W-1:0]});
		write_reg(REG_COUNT, {26'($urandom), 6'(cnt)});
		write_reg(REG_NONE, $urandom);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(int ph);
		int sel, n_cfg, inv_axis, j;
		settle();
		sel = $urandom_range(2);
		span = (sel == 0) ? 32 : (sel == 1) ? 4096 : 8388607;
		ctr = (sel == 2) ? 0 : longint'($urandom_range(16000000)) - 8000000;
		sel = $urandom_range(9);
		case (sel)
			0: n_cfg = 0;
			1: n_cfg = $urandom_range(2, 1);
			2: n_cfg = $urandom_range(63, 33);
			3: n_cfg = MAX_VERTICES;
			default: n_cfg = $urandom_range(16, 3);
		endcase
		if (ph == 1)
			n_cfg = 63;
		n_used = (n_cfg > MAX_VERTICES) ? MAX_VERTICES : n_cfg;
		sel = $urandom_range(9);
		inv_axis = $urandom_range(2);
		for (int a = 0; a < 3; a++) begin
			if (sel < 5 || (sel == 8 && a != inv_axis)) begin
				bound_lo[a] = C_MIN;
				bound_hi[a] = C_MAX;
			end else if (sel < 8) begin
				bound_lo[a] = clamp24(ctr - longint'($urandom_range(span)));
				bound_hi[a] = clamp24(ctr + longint'($urandom_range(span)));
			end else if (sel == 8) begin
				bound_lo[a] = clamp24(ctr + 1 + longint'($urandom_range(span)));
				bound_hi[a] = clamp24(ctr - longint'($urandom_range(span)));
			end else begin
				bound_lo[a] = near_ctr();
				bound_hi[a] = bound_lo[a];
			end
		end
		set_regs(bound_lo[0], bound_lo[1], bound_lo[2], bound_hi[0], bound_hi[1], bound_hi[2],
			n_cfg);
		case (ph % 4)
			0: begin src_idle = 0;  dst_stall <= 0;  end
			1: begin src_idle = 83; dst_stall <= 0;  end
			2: begin src_idle = 0;  dst_stall <= 83; end
			default: begin src_idle = 35; dst_stall <= 35; end
		endcase
		for (int k = 0; k < n_used; k++) begin
			vx[k] = near_ctr();
			vy[k] = (k > 0 && $urandom_range(7) == 0) ? vy[k - 1] : near_ctr();
			send_item(CMD_WRITE, VIDX_W'(k), vx[k], vy[k], any_coord());
		end
		for (int k = n_used; k < PHASE_ITEMS; k++) begin
			if ($urandom_range(9) == 0) begin
				j = $urandom_range(MAX_VERTICES - 1);
				vx[j] = near_ctr();
				vy[j] = near_ctr();
				send_item(CMD_WRITE, VIDX_W'(j), vx[j], vy[j], any_coord());
			end else begin
				send_item(CMD_QUERY, VIDX_W'($urandom), pick_axis(0), pick_axis(1), pick_axis(2));
			end
		end
	endtask

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: degenerate box at the origin, no vertices
		send_item(CMD_QUERY, '0, 0, 0, 0);
		send_item(CMD_QUERY, '0, 1, 0, 0);

		// full-range box, square at the coordinate extremes (horizontal top and bottom)
		settle();
		set_regs(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 4);
		send_item(CMD_WRITE, 5'd0, C_MIN, C_MIN, C_MAX);
		send_item(CMD_WRITE, 5'd1, C_MAX, C_MIN, C_MIN);
		send_item(CMD_WRITE, 5'd2, C_MAX, C_MAX, C_MAX);
		send_item(CMD_WRITE, 5'd3, C_MIN, C_MAX, C_MIN);
		send_item(CMD_WRITE, 5'd31, C_MAX, C_MIN, C_MAX);
		send_item(CMD_QUERY, '0, 0, 0, 0);
		send_item(CMD_QUERY, 5'd31, C_MIN, C_MIN, C_MIN);
		send_item(CMD_QUERY, '0, C_MAX, C_MAX, C_MAX);
		send_item(CMD_QUERY, '0, C_MIN, 0, 0);
		send_item(CMD_QUERY, '0, C_MAX, 0, 0);
		send_item(CMD_QUERY, '0, 0, C_MIN, 0);
		send_item(CMD_QUERY, '0, 0, C_MAX, 0);
		send_item(CMD_QUERY, '0, C_MIN + 1, 5, C_MAX);

		// triangle, flat box in z
		settle();
		set_regs(C_MIN, C_MIN, 0, C_MAX, C_MAX, 0, 3);
		send_item(CMD_QUERY, '0, 0, -100, 0);
		send_item(CMD_QUERY, '0, 0, -100, 1);

		// inverted x bounds admit nothing
		settle();
		set_regs(100, C_MIN, C_MIN, -100, C_MAX, C_MAX, 3);
		send_item(CMD_QUERY, '0, 0, -100, 0);

		for (int ph = 0; ph < PHASES; ph++)
			run_phase(ph);

		settle();
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pip_pkg.sv
sv/point_in_polygon_test.sv
sv/pip_checker.sv
tb/sv/pip_checker.sv
tb/sv/tb_top.sv
